// ===== rtl/xcpf_pkg.sv =====
// Package for the XOR checksum packet framer: payload structs, the job
// descriptor passed from front to back, and the fixed codes and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package xcpf_pkg;

   // Input item kinds.
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_BYTE  = 1'b1;

   // Result status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_TOO_LONG = 2'd1;
   localparam logic [1:0] ST_NO_FRAME = 2'd2;
   localparam logic [1:0] ST_BUSY     = 2'd3;

   // Job operations handed to the back end.
   localparam logic [1:0] OP_ERR = 2'd0;
   localparam logic [1:0] OP_HDR = 2'd1;
   localparam logic [1:0] OP_DAT = 2'd2;

   localparam logic [7:0]  START_MARK     = 8'hAA;
   localparam logic [7:0]  END_MARK       = 8'h55;
   localparam logic [11:0] FRAME_OVERHEAD = 12'd7;
   localparam logic [10:0] LIMIT_RESET    = 11'd1024;

   // Configuration address map.
   localparam int          CSR_ADDR_W      = 3;
   localparam logic        CSR_MAX_PAYLOAD = 1'b0;

   typedef struct packed {
      logic        req_type;
      logic [7:0]  command;
      logic [10:0] payload_length;
      logic [7:0]  data_byte;
   } req_type_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] op;
      logic [1:0] status;
      logic [7:0] first;     // command on a header, payload byte on data
      logic [7:0] len_lo;
      logic [7:0] len_hi;
      logic [7:0] seq;
      logic [7:0] chk;
      logic       close;     // emit checksum and end mark after this job
   } job_type;

endpackage

`default_nettype wire

// ===== rtl/xcpf_fifo.sv =====
// Small register-based queue of job descriptors between front and back end.
// Depends on xcpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xcpf_fifo #(
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire xcpf_pkg::job_type din,
   output logic                  full,
   input  wire logic             pop,
   output xcpf_pkg::job_type     dout,
   output logic                  empty
);
   import xcpf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/xcpf_front.sv =====
// Front end: accepts request items, checks them against the frame state and
// the length limit, keeps the frame state and emits one job per item.
// Depends on xcpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xcpf_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   input  wire xcpf_pkg::req_type_type req_data,
   input  wire logic [10:0]           max_payload,
   input  wire logic                  job_full,
   output logic                       job_push,
   output xcpf_pkg::job_type          job
);
   import xcpf_pkg::*;

   logic [7:0]  seq_ff, seq_in;
   logic        open_ff, open_in;
   logic [10:0] rem_ff, rem_in;
   logic [7:0]  rx_ff, rx_in;
   logic [11:0] total;
   logic [7:0]  len_lo, len_hi, hdr_chk, byte_chk;

   assign job_push = req_push && !job_full;
   assign total    = {1'b0, req_data.payload_length} + FRAME_OVERHEAD;
   assign len_lo   = total[7:0];
   assign len_hi   = {4'b0000, total[11:8]};
   assign hdr_chk  = req_data.command ^ len_lo ^ len_hi ^ seq_ff;
   assign byte_chk = rx_ff ^ req_data.data_byte;

   always_comb begin
      seq_in  = seq_ff;
      open_in = open_ff;
      rem_in  = rem_ff;
      rx_in   = rx_ff;
      job     = '0;
      job.op  = OP_ERR;
      priority if (req_data.req_type == REQ_START && open_ff) begin
         job.status = ST_BUSY;
      end else if (req_data.req_type == REQ_START &&
                   req_data.payload_length > max_payload) begin
         job.status = ST_TOO_LONG;
      end else if (req_data.req_type == REQ_START) begin
         job.op     = OP_HDR;
         job.status = ST_OK;
         job.first  = req_data.command;
         job.len_lo = len_lo;
         job.len_hi = len_hi;
         job.seq    = seq_ff;
         job.chk    = hdr_chk;
         seq_in     = seq_ff + 1'b1;
         if (req_data.payload_length == '0) begin
            job.close = 1'b1;
         end else begin
            open_in = 1'b1;
            rem_in  = req_data.payload_length;
            rx_in   = hdr_chk;
         end
      end else if (!open_ff) begin
         job.status = ST_NO_FRAME;
      end else begin
         job.op     = OP_DAT;
         job.status = ST_OK;
         job.first  = req_data.data_byte;
         job.chk    = byte_chk;
         rem_in     = rem_ff - 1'b1;
         if (rem_ff == 11'd1) begin
            // Last payload byte closes the frame.
            job.close = 1'b1;
            open_in   = 1'b0;
            rx_in     = '0;
         end else begin
            rx_in = byte_chk;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff  <= '0;
         open_ff <= 1'b0;
         rem_ff  <= '0;
         rx_ff   <= '0;
      end else if (job_push) begin
         seq_ff  <= seq_in;
         open_ff <= open_in;
         rem_ff  <= rem_in;
         rx_ff   <= rx_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/xcpf_back.sv =====
// Back end: expands each job into its frame bytes, written into an output
// register that the consumer drains; one byte per cycle while it keeps up.
// Depends on xcpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xcpf_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_empty,
   input  wire xcpf_pkg::job_type job,
   output logic                  job_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output xcpf_pkg::rsp_type     rsp_data
);
   import xcpf_pkg::*;

   logic [2:0] step_ff, step_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff;
   rsp_type    res;
   logic       final_step;
   logic       advance;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign advance   = !job_empty && (!out_valid_ff || rsp_pop);
   assign job_pop   = advance && final_step;

   always_comb begin
      res        = '0;
      res.status = job.status;
      final_step = 1'b1;
      unique case (job.op)
         OP_HDR: begin
            final_step = job.close ? (step_ff == 3'd6) : (step_ff == 3'd4);
            unique case (step_ff)
               3'd0:    res.out_byte = START_MARK;
               3'd1:    res.out_byte = job.first;
               3'd2:    res.out_byte = job.len_lo;
               3'd3:    res.out_byte = job.len_hi;
               3'd4:    res.out_byte = job.seq;
               3'd5:    res.out_byte = job.chk;
               default: begin
                  res.out_byte  = END_MARK;
                  res.frame_end = 1'b1;
               end
            endcase
         end
         OP_DAT: begin
            final_step = job.close ? (step_ff == 3'd2) : (step_ff == 3'd0);
            unique case (step_ff)
               3'd0:    res.out_byte = job.first;
               3'd1:    res.out_byte = job.chk;
               default: begin
                  res.out_byte  = END_MARK;
                  res.frame_end = 1'b1;
               end
            endcase
         end
         default: begin
            // Rejected item: a single zero byte carrying the status.
            res.out_byte = '0;
         end
      endcase
      res.last = final_step;
   end

   always_comb begin
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         step_in      = final_step ? 3'd0 : step_ff + 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= res;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/xor_checksum_packet_framer.sv =====
// XOR checksum packet framer, top level: configuration registers, front end,
// job queue and back end. Depends on xcpf_pkg, xcpf_front, xcpf_fifo, xcpf_back.
// An accepted item's job is written into the job queue, and the back end then
// loads its first result into the output register. One item is accepted per
// cycle while the job queue has room; results leave at one per cycle while
// the consumer pops them; a valid start item yields 5 or 7 bytes. Synchronous
// reset empties the queue and output register, sets the length limit to 1024.
`timescale 1ns / 1ps
`default_nettype none

module xor_checksum_packet_framer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   output logic                                   req_full,
   input  wire xcpf_pkg::req_type_type            req_data,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output xcpf_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [xcpf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);
   import xcpf_pkg::*;

   logic [10:0] max_payload_ff;
   logic        csr_write;
   logic        job_push, job_pop, job_full, job_empty;
   job_type     job_wr, job_rd;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[CSR_ADDR_W-1] == CSR_MAX_PAYLOAD);
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == CSR_MAX_PAYLOAD) ?
                       {21'd0, max_payload_ff} : 32'd0;
   assign req_full   = job_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= LIMIT_RESET;
      end else if (csr_write) begin
         max_payload_ff <= csr_pwdata[10:0];
      end
   end

   xcpf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_data    (req_data),
      .max_payload (max_payload_ff),
      .job_full    (job_full),
      .job_push    (job_push),
      .job         (job_wr)
   );

   xcpf_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .din   (job_wr),
      .full  (job_full),
      .pop   (job_pop),
      .dout  (job_rd),
      .empty (job_empty)
   );

   xcpf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job       (job_rd),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/xcpf_checker.sv =====
// Port-level checks for the XOR checksum packet framer, bound to its top level.
// Depends on xcpf_pkg and xor_checksum_packet_framer.
`timescale 1ns / 1ps
`default_nettype none

module xcpf_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_full,
   input wire logic              rsp_empty,
   input wire logic              rsp_pop,
   input wire xcpf_pkg::rsp_type rsp_data
);
   import xcpf_pkg::*;

   // Queues come out of reset empty and ready for a transfer.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_end_mark: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.frame_end) |->
         (rsp_data.out_byte == END_MARK && rsp_data.last &&
          rsp_data.status == ST_OK))
      else $error("frame end without closing mark");

   a_error_result: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status != ST_OK) |->
         (rsp_data.out_byte == 8'h00 && rsp_data.last && !rsp_data.frame_end))
      else $error("malformed error result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind xor_checksum_packet_framer xcpf_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

`default_nettype wire
